FILE: sv/meter_frame_deframer_unit_defines.svh
// ----------------------------------------------------------------------------
// Meter frame deframer assertion macros
// Shared assertion helpers for the deframer RTL, removable with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef METER_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define METER_FRAME_DEFRAMER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only outside reset.
`define MFD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define MFD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MFD_ASSERT(label, clk, rst_n, prop, msg)
`define MFD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: sv/mfd_pkg.sv
// ----------------------------------------------------------------------------
// Meter frame deframer package
// Frame constants, parser phase codes and the result word type.
// ----------------------------------------------------------------------------
package mfd_pkg;

  localparam logic [7:0]  SYNC_HI         = 8'hAA;
  localparam logic [7:0]  SYNC_LO         = 8'hCC;
  localparam logic [7:0]  CLASS_AMMETER   = 8'hA0;
  localparam logic [7:0]  CLASS_VOLTMETER = 8'hA1;
  localparam logic [7:0]  CLASS_SERIAL    = 8'hA2;
  localparam logic [15:0] METER_LENGTH    = 16'd14;

  typedef enum logic [6:0] {
    PH_HUNT    = 7'b0000001,
    PH_SYNC_LO = 7'b0000010,
    PH_LEN_HI  = 7'b0000100,
    PH_LEN_LO  = 7'b0001000,
    PH_CLASS   = 7'b0010000,
    PH_ID      = 7'b0100000,
    PH_BODY    = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_AMMETER   = 2'd0,
    KIND_VOLTMETER = 2'd1,
    KIND_PASS      = 2'd2,
    KIND_DROP      = 2'd3
  } kind_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  channel;
    logic [31:0] reading_instant;
    logic [31:0] reading_average;
    logic [31:0] reading_maximum;
    logic [7:0]  data_byte;
    logic        frame_end;
  } result_t;

endpackage

FILE: sv/mfd_parser.sv
// ----------------------------------------------------------------------------
// Meter frame deframer parser
// Holds the frame parse state and forms the result word for each input byte.
// ----------------------------------------------------------------------------
`include "meter_frame_deframer_unit_defines.svh"

module mfd_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output mfd_pkg::result_t result
);
  import mfd_pkg::*;

  phase_t      phase_r,   phase_nxt;
  logic [15:0] left_r,    left_nxt;
  logic [15:0] length_r,  length_nxt;
  logic [7:0]  class_r,   class_nxt;
  logic [7:0]  id_r,      id_nxt;
  logic [31:0] rd_r [3];
  logic [31:0] rd_nxt [3];
  logic [15:0] left_dec;
  logic        last;
  logic        byte_meter;
  logic        class_meter;

  assign left_dec    = left_r - 16'd1;
  assign last        = (left_dec == 16'd0);
  assign byte_meter  = (rx_byte == CLASS_AMMETER) || (rx_byte == CLASS_VOLTMETER);
  assign class_meter = (class_r == CLASS_AMMETER) || (class_r == CLASS_VOLTMETER);

  always_comb begin
    phase_nxt  = phase_r;
    left_nxt   = left_r;
    length_nxt = length_r;
    class_nxt  = class_r;
    id_nxt     = id_r;
    rd_nxt     = rd_r;
    result     = '0;
    case (phase_r)
      PH_SYNC_LO: begin
        if (rx_byte == SYNC_LO) begin
          phase_nxt = PH_LEN_HI;
        end else if (rx_byte == SYNC_HI) begin
          phase_nxt = PH_SYNC_LO;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_LEN_HI: begin
        length_nxt = {rx_byte, 8'h00};
        phase_nxt  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_nxt = {length_r[15:8], rx_byte};
        left_nxt   = {length_r[15:8], rx_byte};
        phase_nxt  = ({length_r[15:8], rx_byte} == 16'd0) ? PH_HUNT : PH_CLASS;
      end
      PH_CLASS: begin
        class_nxt = rx_byte;
        id_nxt    = 8'h00;
        rd_nxt[0] = 32'd0;
        rd_nxt[1] = 32'd0;
        rd_nxt[2] = 32'd0;
        left_nxt  = left_dec;
        if (last) begin
          phase_nxt = PH_HUNT;
          if (byte_meter) begin
            result.valid     = 1'b1;
            result.kind      = KIND_DROP;
            result.frame_end = 1'b1;
          end
        end else begin
          phase_nxt = PH_ID;
        end
      end
      PH_ID: begin
        id_nxt   = rx_byte;
        left_nxt = left_dec;
        if (last) begin
          phase_nxt = PH_HUNT;
          if (class_meter) begin
            result.valid     = 1'b1;
            result.kind      = KIND_DROP;
            result.channel   = rx_byte;
            result.frame_end = 1'b1;
          end
        end else begin
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        left_nxt = left_dec;
        if (last) begin
          phase_nxt = PH_HUNT;
        end
        if (class_meter) begin
          rd_nxt[0] = {rd_r[0][23:0], rd_r[1][31:24]};
          rd_nxt[1] = {rd_r[1][23:0], rd_r[2][31:24]};
          rd_nxt[2] = {rd_r[2][23:0], rx_byte};
          if (last) begin
            result.valid     = 1'b1;
            result.channel   = id_r;
            result.frame_end = 1'b1;
            if ((length_r == METER_LENGTH) && (id_r != 8'h00)) begin
              result.kind            = (class_r == CLASS_AMMETER) ? KIND_AMMETER
                                                                  : KIND_VOLTMETER;
              result.reading_instant = {rd_r[0][23:0], rd_r[1][31:24]};
              result.reading_average = {rd_r[1][23:0], rd_r[2][31:24]};
              result.reading_maximum = {rd_r[2][23:0], rx_byte};
            end else begin
              result.kind = KIND_DROP;
            end
          end
        end else if (class_r == CLASS_SERIAL) begin
          result.valid     = 1'b1;
          result.kind      = KIND_PASS;
          result.channel   = id_r;
          result.data_byte = rx_byte;
          result.frame_end = last;
        end
      end
      default: begin
        phase_nxt = (rx_byte == SYNC_HI) ? PH_SYNC_LO : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      left_r   <= 16'd0;
      length_r <= 16'd0;
      class_r  <= 8'h00;
      id_r     <= 8'h00;
      rd_r[0]  <= 32'd0;
      rd_r[1]  <= 32'd0;
      rd_r[2]  <= 32'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      left_r   <= left_nxt;
      length_r <= length_nxt;
      class_r  <= class_nxt;
      id_r     <= id_nxt;
      rd_r     <= rd_nxt;
    end
  end

  // Inside a frame body at least one byte is always still owed.
  `MFD_ASSERT(a_left_nonzero, clk, rst_n, (phase_r == PH_CLASS || phase_r == PH_ID || phase_r == PH_BODY) |-> (left_r != 16'd0), "bytes left is zero inside a frame")
  `MFD_ASSERT(a_left_below_len, clk, rst_n, (phase_r == PH_BODY) |-> (left_r < length_r), "bytes left exceeds frame length in body")
  `MFD_ASSERT(a_rd_clear_at_id, clk, rst_n, (phase_r == PH_ID) |-> (rd_r[0] == 32'd0 && rd_r[1] == 32'd0 && rd_r[2] == 32'd0), "readings not cleared at id byte")

endmodule

FILE: sv/meter_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// Meter frame deframer
// Parses sync, length, class and id of received frames and emits meter
// records, serial passthrough bytes and dropped-frame notices.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake            Word
//   in_      input      in_valid / in_ready  one received byte
//   out_     output     out_valid/out_ready  one record, passthrough or drop
//
// Each byte is parsed in the cycle it is accepted; its result appears in the
// output register on the next cycle. One byte per cycle is sustained while out_ready stays high.
// in_ready is high whenever the output register is empty or being drained.
// Reset (rst_n low, synchronous) returns the parser to the sync hunt.
// ----------------------------------------------------------------------------
`include "meter_frame_deframer_unit_defines.svh"

module meter_frame_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_channel,
  output logic [31:0] out_reading_instant,
  output logic [31:0] out_reading_average,
  output logic [31:0] out_reading_maximum,
  output logic [7:0]  out_data_byte,
  output logic        out_frame_end
);
  import mfd_pkg::*;

  result_t result;
  result_t out_r;
  logic    out_valid_r;
  logic    accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  mfd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (accept),
    .rx_byte (in_rx_byte),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= result.valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= result;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_r.kind;
  assign out_channel         = out_r.channel;
  assign out_reading_instant = out_r.reading_instant;
  assign out_reading_average = out_r.reading_average;
  assign out_reading_maximum = out_r.reading_maximum;
  assign out_data_byte       = out_r.data_byte;
  assign out_frame_end       = out_r.frame_end;

  `MFD_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "output valid after reset")
  `MFD_ASSERT(a_end_on_close, clk, rst_n, (out_valid && out_kind != KIND_PASS) |-> out_frame_end, "record or drop without frame end")
  `MFD_ASSERT(a_readings_zero, clk, rst_n, (out_valid && (out_kind == KIND_PASS || out_kind == KIND_DROP)) |-> (out_reading_instant == 32'd0 && out_reading_average == 32'd0 && out_reading_maximum == 32'd0), "readings on a non-record word")
  `MFD_ASSERT(a_data_zero, clk, rst_n, (out_valid && out_kind != KIND_PASS) |-> (out_data_byte == 8'h00), "data byte on a non-passthrough word")

endmodule
